FILE: src/trpa_pkg.sv
// ----------------------------------------------------------------------------
// trpa_pkg
// Shared widths, constants, types and a helper function for the tilt unit.
// ----------------------------------------------------------------------------
package trpa_pkg;

    localparam int IN_W              = 16;
    localparam int ROLL_W            = 16;
    localparam int PITCH_W           = 15;
    localparam int S_DATA_W          = 3 * IN_W;
    localparam int M_DATA_W          = 32;
    localparam int IN_SHIFT          = 14;
    localparam int SQ_W              = 2 * IN_W;
    localparam int SQRT_STEPS        = (SQ_W + 2 * IN_SHIFT) / 2;
    localparam int ROOT_W            = SQRT_STEPS;
    localparam int REM_W             = ROOT_W + 2;
    localparam int VEC_W             = 34;
    localparam int ACC_W             = 26;
    localparam int ROUND_SHIFT       = 9;
    localparam int Q_W               = ACC_W + 1 - ROUND_SHIFT;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int DEG180    = 11796480;
    localparam int DEG90     = 5898240;
    localparam int ROLL_LIM  = 23040;
    localparam int PITCH_LIM = 11520;

    // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
    localparam int ATAN_TAB [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [IN_W-1:0] az;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] ax;
    } sample_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   bits;
    } sqrt_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
        logic                    hold;
    } vec_t;

    // Handles a zero ordinate and folds a negative abscissa into the right half plane.
    function automatic vec_t vec_setup(input logic signed [VEC_W-1:0] x,
                                       input logic signed [VEC_W-1:0] y);
        vec_t v;
        v.x    = x;
        v.y    = y;
        v.acc  = '0;
        v.hold = 1'b0;
        if (y == '0) begin
            v.hold = 1'b1;
            v.acc  = x[VEC_W-1] ? ACC_W'(DEG180) : '0;
        end else if (x[VEC_W-1]) begin
            if (!y[VEC_W-1]) begin
                v.x   = y;
                v.y   = -x;
                v.acc = ACC_W'(DEG90);
            end else begin
                v.x   = -y;
                v.y   = x;
                v.acc = -ACC_W'(DEG90);
            end
        end
        return v;
    endfunction

endpackage

FILE: src/trpa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// trpa_sqrt_cell
// One digit step of the integer square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module trpa_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               i_valid,
    input  trpa_pkg::sqrt_t    i_sq,
    input  trpa_pkg::sample_t  i_smp,
    output logic               o_valid,
    output trpa_pkg::sqrt_t    o_sq,
    output trpa_pkg::sample_t  o_smp
);

    logic                       valid_reg;
    trpa_pkg::sqrt_t            sq_reg;
    trpa_pkg::sqrt_t            sq_next;
    trpa_pkg::sample_t          smp_reg;
    logic [trpa_pkg::REM_W+1:0] cur;
    logic [trpa_pkg::REM_W+1:0] trial;
    logic [trpa_pkg::REM_W+1:0] diff;

    always_comb begin
        cur   = {i_sq.rem, i_sq.bits[trpa_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, i_sq.root, 2'b01};
        diff  = cur - trial;
        sq_next.bits = {i_sq.bits[trpa_pkg::SQ_W-3:0], 2'b00};
        if (cur >= trial) begin
            sq_next.rem  = diff[trpa_pkg::REM_W-1:0];
            sq_next.root = {i_sq.root[trpa_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            sq_next.rem  = cur[trpa_pkg::REM_W-1:0];
            sq_next.root = {i_sq.root[trpa_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg  <= sq_next;
            smp_reg <= i_smp;
        end
    end

    assign o_valid = valid_reg;
    assign o_sq    = sq_reg;
    assign o_smp   = smp_reg;

endmodule

FILE: src/trpa_cordic_cell.sv
// ----------------------------------------------------------------------------
// trpa_cordic_cell
// One vectoring CORDIC iteration, applied to the roll and the pitch vector.
// ----------------------------------------------------------------------------
module trpa_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            i_valid,
    input  trpa_pkg::vec_t  i_roll,
    input  trpa_pkg::vec_t  i_pitch,
    output logic            o_valid,
    output trpa_pkg::vec_t  o_roll,
    output trpa_pkg::vec_t  o_pitch
);

    localparam logic signed [trpa_pkg::ACC_W-1:0] ANGLE =
        trpa_pkg::ACC_W'(trpa_pkg::ATAN_TAB[STEP]);

    logic           valid_reg;
    trpa_pkg::vec_t roll_reg;
    trpa_pkg::vec_t pitch_reg;
    trpa_pkg::vec_t roll_next;
    trpa_pkg::vec_t pitch_next;

    function automatic trpa_pkg::vec_t rotate(input trpa_pkg::vec_t v);
        trpa_pkg::vec_t                 r;
        logic signed [trpa_pkg::VEC_W-1:0] xs;
        logic signed [trpa_pkg::VEC_W-1:0] ys;
        r  = v;
        xs = v.x >>> STEP;
        ys = v.y >>> STEP;
        if (!v.hold) begin
            if (!v.y[trpa_pkg::VEC_W-1]) begin
                r.x   = v.x + ys;
                r.y   = v.y - xs;
                r.acc = v.acc + ANGLE;
            end else begin
                r.x   = v.x - ys;
                r.y   = v.y + xs;
                r.acc = v.acc - ANGLE;
            end
        end
        return r;
    endfunction

    always_comb begin
        roll_next  = rotate(i_roll);
        pitch_next = rotate(i_pitch);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_roll  = roll_reg;
    assign o_pitch = pitch_reg;

endmodule

FILE: src/tilt_roll_pitch_from_accel_unit.sv
// ----------------------------------------------------------------------------
// tilt_roll_pitch_from_accel_unit
// Roll and pitch angles from one raw three-axis acceleration sample.
// ----------------------------------------------------------------------------
// The unit takes one sample in every clock cycle while s_tready is high and
// returns roll = atan2(y, z) and pitch = atan2(-x, sqrt(y*y + z*z)) in signed
// units of 1/128 degree. CORDIC_STAGES above 24 count as 24. Each sample passes
// through these registers in order: the squares, registered at the accepting
// edge, their sum, the chain of square-root digit cells, quadrant folding, one
// register per CORDIC cell, rounding and the output register. A two-entry output
// buffer lets the unit keep accepting samples while one finished result waits to
// be taken; s_tready drops while both entries are full.
module tilt_roll_pitch_from_accel_unit #(
    parameter int CORDIC_STAGES = trpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x, accel_y, accel_z
    input  logic [trpa_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // roll_angle, pitch_angle, one zero pad bit
    output logic [trpa_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int NUM_STAGES = (CORDIC_STAGES > trpa_pkg::ATAN_LEN) ?
                                trpa_pkg::ATAN_LEN : CORDIC_STAGES;

    logic adv;
    trpa_pkg::sample_t s_smp;

    logic                                  valid1_reg;
    trpa_pkg::sample_t                     smp1_reg;
    logic [trpa_pkg::SQ_W-2:0]             yy1_reg;
    logic [trpa_pkg::SQ_W-2:0]             zz1_reg;
    logic signed [trpa_pkg::SQ_W-1:0]      prod_y;
    logic signed [trpa_pkg::SQ_W-1:0]      prod_z;

    logic              sq_valid [0:trpa_pkg::SQRT_STEPS];
    trpa_pkg::sqrt_t   sq_st    [0:trpa_pkg::SQRT_STEPS];
    trpa_pkg::sample_t sq_smp   [0:trpa_pkg::SQRT_STEPS];

    logic              cv_valid [0:NUM_STAGES];
    trpa_pkg::vec_t    cv_roll  [0:NUM_STAGES];
    trpa_pkg::vec_t    cv_pitch [0:NUM_STAGES];
    trpa_pkg::sample_t pre_smp;

    logic                                 r_valid_reg;
    logic signed [trpa_pkg::ROLL_W-1:0]   r_roll_reg;
    logic signed [trpa_pkg::PITCH_W-1:0]  r_pitch_reg;
    logic signed [trpa_pkg::ROLL_W-1:0]   roll_full;
    logic signed [trpa_pkg::ROLL_W-1:0]   pitch_full;
    logic [trpa_pkg::M_DATA_W-1:0]        r_data;
    logic                                 r_take;

    logic                          m_tvalid_reg;
    logic [trpa_pkg::M_DATA_W-1:0] m_data_reg;
    logic                          skid_valid_reg;
    logic [trpa_pkg::M_DATA_W-1:0] skid_data_reg;

    function automatic logic signed [trpa_pkg::ROLL_W-1:0] round_angle(
        input logic signed [trpa_pkg::ACC_W-1:0] acc,
        input logic [trpa_pkg::Q_W-1:0]          lim
    );
        logic [trpa_pkg::ACC_W-1:0] mag;
        logic [trpa_pkg::ACC_W:0]   sum;
        logic [trpa_pkg::Q_W-1:0]   q;
        mag = acc[trpa_pkg::ACC_W-1] ? -acc : acc;
        sum = {1'b0, mag} + (trpa_pkg::ACC_W + 1)'(1 << (trpa_pkg::ROUND_SHIFT - 1));
        q   = sum[trpa_pkg::ACC_W:trpa_pkg::ROUND_SHIFT];
        if (q > lim) begin
            q = lim;
        end
        if (acc[trpa_pkg::ACC_W-1]) begin
            q = -q;
        end
        return q[trpa_pkg::ROLL_W-1:0];
    endfunction

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign s_smp    = trpa_pkg::sample_t'(s_tdata);

    assign prod_y = s_smp.ay * s_smp.ay;
    assign prod_z = s_smp.az * s_smp.az;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg  <= 1'b0;
            sq_valid[0] <= 1'b0;
        end else if (adv) begin
            valid1_reg  <= s_tvalid;
            sq_valid[0] <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            smp1_reg         <= s_smp;
            yy1_reg          <= prod_y[trpa_pkg::SQ_W-2:0];
            zz1_reg          <= prod_z[trpa_pkg::SQ_W-2:0];
            sq_smp[0]        <= smp1_reg;
            sq_st[0].rem     <= '0;
            sq_st[0].root    <= '0;
            sq_st[0].bits    <= {1'b0, yy1_reg} + {1'b0, zz1_reg};
        end
    end

    for (genvar k = 0; k < trpa_pkg::SQRT_STEPS; k++) begin : g_sqrt
        trpa_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .i_valid (sq_valid[k]),
            .i_sq    (sq_st[k]),
            .i_smp   (sq_smp[k]),
            .o_valid (sq_valid[k+1]),
            .o_sq    (sq_st[k+1]),
            .o_smp   (sq_smp[k+1])
        );
    end

    assign pre_smp = sq_smp[trpa_pkg::SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_valid[0] <= 1'b0;
        end else if (adv) begin
            cv_valid[0] <= sq_valid[trpa_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cv_roll[0]  <= trpa_pkg::vec_setup(
                trpa_pkg::VEC_W'(pre_smp.az) <<< trpa_pkg::IN_SHIFT,
                trpa_pkg::VEC_W'(pre_smp.ay) <<< trpa_pkg::IN_SHIFT);
            cv_pitch[0] <= trpa_pkg::vec_setup(
                trpa_pkg::VEC_W'(sq_st[trpa_pkg::SQRT_STEPS].root),
                -(trpa_pkg::VEC_W'(pre_smp.ax) <<< trpa_pkg::IN_SHIFT));
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cordic
        trpa_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .i_valid (cv_valid[k]),
            .i_roll  (cv_roll[k]),
            .i_pitch (cv_pitch[k]),
            .o_valid (cv_valid[k+1]),
            .o_roll  (cv_roll[k+1]),
            .o_pitch (cv_pitch[k+1])
        );
    end

    assign roll_full  = round_angle(cv_roll[NUM_STAGES].acc,
                                    trpa_pkg::Q_W'(trpa_pkg::ROLL_LIM));
    assign pitch_full = round_angle(cv_pitch[NUM_STAGES].acc,
                                    trpa_pkg::Q_W'(trpa_pkg::PITCH_LIM));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (adv) begin
            r_valid_reg <= cv_valid[NUM_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_roll_reg  <= roll_full;
            r_pitch_reg <= pitch_full[trpa_pkg::PITCH_W-1:0];
        end
    end

    assign r_data = {1'b0, r_pitch_reg, r_roll_reg};
    assign r_take = r_valid_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_tvalid_reg) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= r_take;
            end
        end else if (r_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_tvalid_reg) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : r_data;
        end else if (r_take) begin
            skid_data_reg <= r_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("Skid buffer holds a transaction while the output is empty.");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("Skid buffer filled without an output stall.");

    a_sqrt_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid[trpa_pkg::SQRT_STEPS] |->
        (sq_st[trpa_pkg::SQRT_STEPS].rem <=
         trpa_pkg::REM_W'({sq_st[trpa_pkg::SQRT_STEPS].root, 1'b0})))
        else $error("Square root remainder exceeds twice the root.");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |->
        ($signed(m_data_reg[15:0]) >= -trpa_pkg::ROLL_LIM) &&
        ($signed(m_data_reg[15:0]) <= trpa_pkg::ROLL_LIM) &&
        ($signed(m_data_reg[30:16]) >= -trpa_pkg::PITCH_LIM) &&
        ($signed(m_data_reg[30:16]) <= trpa_pkg::PITCH_LIM) &&
        !m_data_reg[31])
        else $error("Output angle outside its range.");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the accelerometer roll and pitch unit.
// ----------------------------------------------------------------------------
// Samples are sent over the input stream. For each accepted sample a local
// fixed-point model works out the roll and pitch angles: an integer square
// root and a CORDIC vectoring loop at the unit's stage count. Each output
// transaction is checked, field by field, against the oldest prediction that
// is still waiting. The run starts with directed extremes and special angles.
// Random tilts follow under three flow-control mixes on the two streams.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_N   = trpa_pkg::CORDIC_STAGES_DEF;
    localparam int USED_STAGES = (CORDIC_N > trpa_pkg::ATAN_LEN) ?
                                 trpa_pkg::ATAN_LEN : CORDIC_N;
    localparam int LATENCY    = USED_STAGES + 34;

    typedef struct packed {
        logic signed [trpa_pkg::IN_W-1:0]    ax;
        logic signed [trpa_pkg::IN_W-1:0]    ay;
        logic signed [trpa_pkg::IN_W-1:0]    az;
        logic signed [trpa_pkg::ROLL_W-1:0]  roll;
        logic signed [trpa_pkg::PITCH_W-1:0] pitch;
    } tilt_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [trpa_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [trpa_pkg::M_DATA_W-1:0] m_tdata;

    tilt_t angles_due[$];
    tilt_t oldest;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    errors         = 0;
    int    items_sent     = 0;
    int    results_seen   = 0;

    tilt_roll_pitch_from_accel_unit #(
        .CORDIC_STAGES(CORDIC_N)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint atan_step(int i);
        case (i)
            0: return 2949120;   1: return 1740967;   2: return 919879;
            3: return 466945;    4: return 234379;    5: return 117304;
            6: return 58666;     7: return 29335;     8: return 14668;
            9: return 7334;      10: return 3667;     11: return 1833;
            12: return 917;      13: return 458;      14: return 229;
            15: return 115;      16: return 57;       17: return 29;
            18: return 14;       19: return 7;        20: return 4;
            21: return 2;        22: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned rem = n;
        longint unsigned root = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // Angle of the vector (xa, ya) in units of 2^-16 degree.
    function automatic longint heading_q16(longint xa, longint ya);
        longint x = xa;
        longint y = ya;
        longint acc = 0;
        longint t, xs, ys;
        if (y == 0)
            return (x >= 0) ? 0 : trpa_pkg::DEG180;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y;
                y = -t;
                acc = trpa_pkg::DEG90;
            end else begin
                x = -y;
                y = t;
                acc = -trpa_pkg::DEG90;
            end
        end
        for (int i = 0; i < USED_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc += atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                acc -= atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint round_clamp(longint acc, longint lim);
        longint mag = (acc < 0) ? -acc : acc;
        longint q = (mag + 256) / 512;
        if (q > lim)
            q = lim;
        return (acc < 0) ? -q : q;
    endfunction

    function automatic tilt_t predict_tilt(logic signed [trpa_pkg::IN_W-1:0] ax,
                                           logic signed [trpa_pkg::IN_W-1:0] ay,
                                           logic signed [trpa_pkg::IN_W-1:0] az);
        tilt_t res;
        longint sx = ax;
        longint sy = ay;
        longint sz = az;
        longint unsigned sq = longint'(sy * sy + sz * sz);
        longint r = longint'(root_floor(sq << (2 * trpa_pkg::IN_SHIFT)));
        longint roll, pitch;
        roll  = round_clamp(heading_q16(sz * 16384, sy * 16384), trpa_pkg::ROLL_LIM);
        pitch = round_clamp(heading_q16(r, -sx * 16384), trpa_pkg::PITCH_LIM);
        res.ax    = ax;
        res.ay    = ay;
        res.az    = az;
        res.roll  = trpa_pkg::ROLL_W'(roll);
        res.pitch = trpa_pkg::PITCH_W'(pitch);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (angles_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    oldest = angles_due.pop_front();
                    if (m_tdata[trpa_pkg::ROLL_W-1:0] !== oldest.roll)
                        report_mismatch($sformatf("roll %0d, want %0d (x=%0d y=%0d z=%0d)",
                            $signed(m_tdata[trpa_pkg::ROLL_W-1:0]), oldest.roll,
                            oldest.ax, oldest.ay, oldest.az));
                    if (m_tdata[trpa_pkg::ROLL_W+trpa_pkg::PITCH_W-1:trpa_pkg::ROLL_W] !==
                        oldest.pitch)
                        report_mismatch($sformatf("pitch %0d, want %0d (x=%0d y=%0d z=%0d)",
                            $signed(m_tdata[trpa_pkg::ROLL_W+trpa_pkg::PITCH_W-1:
                                            trpa_pkg::ROLL_W]),
                            oldest.pitch, oldest.ax, oldest.ay, oldest.az));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(input logic signed [trpa_pkg::IN_W-1:0] ax,
                               input logic signed [trpa_pkg::IN_W-1:0] ay,
                               input logic signed [trpa_pkg::IN_W-1:0] az);
        trpa_pkg::sample_t smp;
        smp.ax = ax;
        smp.ay = ay;
        smp.az = az;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do
            @(posedge aclk);
        while (!s_tready);
        angles_due.push_back(predict_tilt(ax, ay, az));
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_angles();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(0, 0, 0);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(0, 0, 16384);
        send_sample(0, 0, -16384);
        send_sample(0, 0, -1);
        send_sample(0, 16384, 0);
        send_sample(0, -32768, 0);
        send_sample(0, 1, -32768);
        send_sample(0, -1, -32768);
        send_sample(0, 12000, -9000);
        send_sample(0, -12000, -9000);
        send_sample(-32768, 0, 0);
        send_sample(32767, 0, 0);
        send_sample(-1, 0, 0);
        send_sample(1, 0, 0);
        send_sample(-32768, 1, 0);
        send_sample(32767, 0, -1);
        send_sample(16384, 16384, 16384);
        send_sample(-1, -1, -1);
        send_sample(5, -7, 3);
        wait_for_results();
    endtask

    function automatic logic signed [trpa_pkg::IN_W-1:0] pick_corner();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic logic signed [trpa_pkg::IN_W-1:0] pick_within(int g);
        return trpa_pkg::IN_W'(int'($urandom_range(0, 2 * g)) - g);
    endfunction

    task automatic test_random_tilts(int count, int idle_pct, int stall_pct);
        logic signed [trpa_pkg::IN_W-1:0] ax, ay, az;
        int mode, g;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            g    = $urandom_range(4000, 16384);
            ax   = trpa_pkg::IN_W'($urandom);
            ay   = trpa_pkg::IN_W'($urandom);
            az   = trpa_pkg::IN_W'($urandom);
            if (mode >= 4 && mode <= 6) begin
                ax = pick_within(g);
                ay = pick_within(g);
                az = pick_within(g);
            end else if (mode == 7) begin
                ax = pick_within(3);
                ay = pick_within(3);
                az = pick_within(3);
            end else if (mode == 8) begin
                case ($urandom_range(0, 2))
                    0: ay = '0;
                    1: az = '0;
                    default: begin
                        ay = '0;
                        az = '0;
                    end
                endcase
            end else if (mode == 9) begin
                ax = pick_corner();
                ay = pick_corner();
                az = pick_corner();
            end
            send_sample(ax, ay, az);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_angles();
        test_random_tilts(130, 14, 86);
        test_random_tilts(130, 86, 14);
        test_random_tilts(140, 0, 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (angles_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", angles_due.size()));
        $display("Sent %0d samples: extremes, zero and folded quadrants, random tilts.",
                 items_sent);
        $display("Checked %0d results under three flow-control mixes, %0d mismatches.",
                 results_seen, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Run stopped by the watchdog.");
        $display("FAILURE");
        $finish;
    end

endmodule
